### rtl/core/assert_macros.svh
// Assertion macros for the RTL files that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

### rtl/core/bil_pkg.sv
// Types and constants shared by the bounded indexed list modules.
`default_nettype none
package bil_pkg;

  localparam int DEPTH     = 16;
  localparam int DATA_BITS = 32;
  localparam int IDX_W     = $clog2(DEPTH);
  localparam int CNT_W     = $clog2(DEPTH + 1);
  localparam int POS_W     = 5;
  localparam int KIND_W    = 3;

  typedef enum logic [KIND_W-1:0] {
    KIND_PUSH_FRONT = 3'd0,
    KIND_PUSH_BACK  = 3'd1,
    KIND_POP_FRONT  = 3'd2,
    KIND_POP_BACK   = 3'd3,
    KIND_INSERT_AT  = 3'd4,
    KIND_ERASE_AT   = 3'd5,
    KIND_READ_AT    = 3'd6
  } kind_t;

  typedef struct packed {
    logic [KIND_W-1:0]           kind;
    logic [POS_W-1:0]            position;
    logic signed [DATA_BITS-1:0] value;
  } req_t;

  typedef struct packed {
    logic signed [DATA_BITS-1:0] result_value;
    logic                        ok;
    logic [CNT_W-1:0]            entry_count;
    logic signed [DATA_BITS-1:0] front_value;
    logic signed [DATA_BITS-1:0] back_value;
  } rsp_t;

  // Shift command broadcast to every cell of the chain.
  typedef struct packed {
    logic                 ins;
    logic                 del;
    logic [IDX_W-1:0]     idx;
    logic [DATA_BITS-1:0] word;
  } cell_ctl_t;

endpackage
`default_nettype wire

### rtl/core/bil_cell.sv
// One slot of the list: holds a word and shifts toward or away from its neighbors.
`default_nettype none
module bil_cell
  import bil_pkg::*;
(
  input  logic                 clk,
  input  cell_ctl_t            ctl,
  input  logic [IDX_W-1:0]     slot,
  input  logic [DATA_BITS-1:0] left_word,
  input  logic [DATA_BITS-1:0] right_word,
  input  logic [IDX_W-1:0]     probe,
  output logic [DATA_BITS-1:0] word,
  output logic [DATA_BITS-1:0] probe_word
);

  // Slots above the fill level may take junk; they are never read before written.
  always_ff @(posedge clk) begin
    if (ctl.ins) begin
      if (slot == ctl.idx) begin
        word <= ctl.word;
      end else if (slot > ctl.idx) begin
        word <= left_word;
      end
    end else if (ctl.del && (slot >= ctl.idx)) begin
      word <= right_word;
    end
  end

  assign probe_word = (slot == probe) ? word : '0;

endmodule
`default_nettype wire

### rtl/core/bounded_indexed_list.sv
// Top level of the bounded indexed list: decode, cell chain and result register.
//
//   channel | direction | payload | handshake
//   req     | in        | req_t   | req_valid / req_stall
//   rsp     | out       | rsp_t   | rsp_valid / rsp_stall
//
// The cell chain shifts on the edge that accepts an item, and the front and back
// words are read from the updated chain while the item is pending and can move.
// No new item is accepted while one is pending; the input stalls until it has moved.
// Reset clears the count and the handshake state and stalls the input; the slot
// words hold no reset.
// A stalled output holds its item, and a further item waits until it has moved.
`default_nettype none
module bounded_indexed_list
  import bil_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

`include "assert_macros.svh"

  logic                       accept;
  logic                       move;
  logic                       pend;
  logic                       pend_ok;
  logic [DATA_BITS-1:0]       pend_val;
  logic [CNT_W-1:0]           count;
  logic [CNT_W-1:0]           count_next;
  logic [CNT_W-1:0]           count_m1;
  logic [POS_W-1:0]           pos_m1;
  logic                       op_ok;
  logic                       op_ins;
  logic                       op_del;
  logic                       op_take;
  logic [IDX_W-1:0]           op_idx;
  logic                       rd_range;
  logic                       ins_range;
  logic                       not_full;
  logic [IDX_W-1:0]           probe;
  logic [DATA_BITS-1:0]       probe_or;
  cell_ctl_t                  ctl;
  logic [DATA_BITS-1:0]       cell_word  [DEPTH];
  logic [DATA_BITS-1:0]       probe_word [DEPTH];

  assign req_stall = pend || rst;
  assign accept    = req_valid && !req_stall;
  assign move      = pend && (!rsp_valid || !rsp_stall);

  assign pos_m1    = req.position - POS_W'(1);
  assign count_m1  = count - CNT_W'(1);
  assign not_full  = count < CNT_W'(DEPTH);
  assign rd_range  = (req.position != '0) && ({1'b0, req.position} <= (POS_W+1)'(count));
  assign ins_range = not_full && (req.position != '0)
                     && ({1'b0, req.position} <= (POS_W+1)'(count) + (POS_W+1)'(1));

  always_comb begin
    op_ok   = 1'b0;
    op_ins  = 1'b0;
    op_del  = 1'b0;
    op_take = 1'b0;
    op_idx  = '0;
    unique case (kind_t'(req.kind))
      KIND_PUSH_FRONT: begin
        op_ok  = not_full;
        op_ins = 1'b1;
      end
      KIND_PUSH_BACK: begin
        op_ok  = not_full;
        op_ins = 1'b1;
        op_idx = count[IDX_W-1:0];
      end
      KIND_POP_FRONT: begin
        op_ok   = count != '0;
        op_del  = 1'b1;
        op_take = 1'b1;
      end
      KIND_POP_BACK: begin
        op_ok   = count != '0;
        op_del  = 1'b1;
        op_take = 1'b1;
        op_idx  = count_m1[IDX_W-1:0];
      end
      KIND_INSERT_AT: begin
        op_ok  = ins_range;
        op_ins = 1'b1;
        op_idx = pos_m1[IDX_W-1:0];
      end
      KIND_ERASE_AT: begin
        op_ok   = rd_range;
        op_del  = 1'b1;
        op_take = 1'b1;
        op_idx  = pos_m1[IDX_W-1:0];
      end
      KIND_READ_AT: begin
        op_ok   = rd_range;
        op_take = 1'b1;
        op_idx  = pos_m1[IDX_W-1:0];
      end
      default: begin
        op_ok = 1'b0;
      end
    endcase
  end

  always_comb begin
    count_next = count;
    if (op_ok && op_ins) begin
      count_next = count + CNT_W'(1);
    end else if (op_ok && op_del) begin
      count_next = count_m1;
    end
  end

  assign ctl.ins  = accept && op_ok && op_ins;
  assign ctl.del  = accept && op_ok && op_del;
  assign ctl.idx  = op_idx;
  assign ctl.word = req.value;

  // While an item is pending the chain is stable and the probe looks at the back.
  assign probe = pend ? count_m1[IDX_W-1:0] : op_idx;

  genvar gi;
  generate
    for (gi = 0; gi < DEPTH; gi++) begin : g_cell
      logic [DATA_BITS-1:0] left_in;
      logic [DATA_BITS-1:0] right_in;
      if (gi == 0) begin : g_first
        assign left_in = '0;
      end else begin : g_left
        assign left_in = cell_word[gi-1];
      end
      if (gi == DEPTH - 1) begin : g_last
        assign right_in = '0;
      end else begin : g_right
        assign right_in = cell_word[gi+1];
      end
      bil_cell u_cell (
        .clk        (clk),
        .ctl        (ctl),
        .slot       (IDX_W'(gi)),
        .left_word  (left_in),
        .right_word (right_in),
        .probe      (probe),
        .word       (cell_word[gi]),
        .probe_word (probe_word[gi])
      );
    end
  endgenerate

  always_comb begin
    probe_or = '0;
    for (int i = 0; i < DEPTH; i++) begin
      probe_or = probe_or | probe_word[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend      <= 1'b0;
      rsp_valid <= 1'b0;
      count     <= '0;
    end else begin
      if (accept) begin
        pend     <= 1'b1;
        count    <= count_next;
        pend_ok  <= op_ok;
        pend_val <= (op_ok && op_take) ? probe_or : '0;
      end
      if (move) begin
        pend                 <= 1'b0;
        rsp_valid            <= 1'b1;
        rsp.result_value     <= pend_val;
        rsp.ok               <= pend_ok;
        rsp.entry_count      <= count;
        rsp.front_value      <= (count != '0) ? cell_word[0] : '0;
        rsp.back_value       <= (count != '0) ? probe_or : '0;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  `ASSERT_SAME(a_count_max, clk, rst, 1'b1, count <= CNT_W'(DEPTH))
  `ASSERT_NEXT(a_refused_keeps_count, clk, rst, accept && !op_ok, count == $past(count))
  `ASSERT_NEXT(a_push_grows, clk, rst, accept && op_ok && op_ins,
               count == $past(count) + CNT_W'(1))
  `ASSERT_SAME(a_empty_zero, clk, rst, rsp_valid && (rsp.entry_count == '0),
               (rsp.front_value == '0) && (rsp.back_value == '0))

endmodule
`default_nettype wire
